### src/dpts_pkg.sv
// Package for the binary64 power-of-two scaler.
// Holds field widths and format constants; no dependencies.
`default_nettype none
package dpts_pkg;
    localparam int unsigned WORD_W  = 64;
    localparam int unsigned SCALE_W = 32;
    localparam int unsigned FRAC_W  = 52;
    localparam int unsigned EXP_W   = 11;
    localparam int unsigned SIG_W   = 53;
    localparam int unsigned LZC_W   = 6;
    localparam int unsigned SUM_W   = 34;
    localparam int unsigned SHIFT_W = 6;
    localparam logic [EXP_W-1:0] EXP_MAX = 11'h7FF;
    localparam int signed   UNDER_LIM = 54;
endpackage
`default_nettype wire

### src/double_power_of_two_scaler.sv
// Top level of the binary64 power-of-two scaler (ldexp).
// Depends on dpts_pkg for widths and format constants.
`default_nettype none
// Usage:
// The input channel carries value_bits (a binary64 pattern) and a signed scale;
// a transfer happens on a rising edge with in_valid high and in_stall low.
// The output channel carries result_bits = value_bits * 2**scale, rounded to
// nearest even; a transfer happens with out_valid high and out_stall low.
// Zero, infinity and NaN pass through unchanged; overflow gives signed
// infinity and deep underflow gives signed zero.
// The pipeline has four register stages: normalize with a leading-zero count,
// exponent sum, classify and align shift, then rounding into the output
// register. One item is taken every cycle while the receiver does not stall.
// Each stage advances when it or any stage after it has room, so bubbles are
// squeezed out while the receiver stalls. in_stall rises only when the output
// register holds an untaken result, the receiver stalls and every earlier
// stage holds an item, so nothing is lost or repeated.
// Reset clears all valid bits at once; an input transfer can happen at the
// first rising edge after rst_n is released.
module double_power_of_two_scaler
    import dpts_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_stall,
    input  wire logic [WORD_W-1:0]         value_bits,
    input  wire logic signed [SCALE_W-1:0] scale,
    output logic                           out_valid,
    input  wire logic                      out_stall,
    output logic [WORD_W-1:0]              result_bits
);
    // Per-stage advance enables: a stage moves when it or anything after it
    // has room.
    logic en4, en3, en2, en1;
    assign en4 = !out_valid || !out_stall;
    logic v1_reg, v2_reg, v3_reg;
    assign en3 = en4 || !v3_reg;
    assign en2 = en3 || !v2_reg;
    assign en1 = en2 || !v1_reg;
    assign in_stall = !en1;

    // Stage 1: classify and normalize a subnormal significand.
    logic              s1_pass_reg, s1_sign_reg;
    logic [WORD_W-1:0] s1_raw_reg;
    logic [SIG_W-1:0]  s1_sig_reg;
    logic signed [12:0] s1_exp_reg;
    logic signed [SCALE_W-1:0] s1_scale_reg;

    logic [EXP_W-1:0]  in_exp;
    logic [FRAC_W-1:0] in_frac;
    logic [LZC_W-1:0]  lz;
    assign in_exp  = value_bits[62:52];
    assign in_frac = value_bits[51:0];

    always_comb
    begin
        lz = '0;
        for (int i = 0; i < FRAC_W; i++)
        begin
            if (in_frac[i])
            begin
                lz = LZC_W'(FRAC_W - i);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_pass_reg  <= (in_exp == EXP_MAX) || (value_bits[62:0] == '0);
            s1_sign_reg  <= value_bits[63];
            s1_raw_reg   <= value_bits;
            s1_scale_reg <= scale;
            if (in_exp == '0)
            begin
                s1_sig_reg <= SIG_W'({1'b0, in_frac} << lz);
                s1_exp_reg <= 13'sd1 - 13'($signed({1'b0, lz}));
            end
            else
            begin
                s1_sig_reg <= {1'b1, in_frac};
                s1_exp_reg <= 13'($signed({1'b0, in_exp}));
            end
        end
    end

    // Stage 2: wide exponent sum.
    logic              s2_pass_reg, s2_sign_reg;
    logic [WORD_W-1:0] s2_raw_reg;
    logic [SIG_W-1:0]  s2_sig_reg;
    logic signed [SUM_W-1:0] s2_sum_reg;

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            s2_pass_reg <= s1_pass_reg;
            s2_sign_reg <= s1_sign_reg;
            s2_raw_reg  <= s1_raw_reg;
            s2_sig_reg  <= s1_sig_reg;
            s2_sum_reg  <= SUM_W'(s1_exp_reg) + SUM_W'(s1_scale_reg);
        end
    end

    // Stage 3: decide the case and shift the significand into place.
    typedef enum logic [2:0] {K_PASS, K_INF, K_ZERO, K_SUB, K_NORM} kind_t;
    kind_t             s3_kind_reg;
    logic              s3_sign_reg;
    logic [WORD_W-1:0] s3_raw_reg;
    logic [EXP_W-1:0]  s3_exp_reg;
    logic [SIG_W-1:0]  s3_q_reg;
    logic              s3_half_reg, s3_sticky_reg;

    logic [SHIFT_W-1:0] sh;
    logic [2*SIG_W-1:0] wide;
    assign sh   = SHIFT_W'(SUM_W'(1) - s2_sum_reg);
    assign wide = {s2_sig_reg, {SIG_W{1'b0}}} >> sh;

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            s3_sign_reg   <= s2_sign_reg;
            s3_raw_reg    <= s2_raw_reg;
            s3_exp_reg    <= s2_sum_reg[EXP_W-1:0];
            s3_half_reg   <= wide[SIG_W-1];
            s3_sticky_reg <= |wide[SIG_W-2:0];
            // A normal result keeps the significand as it is.
            if (s2_sum_reg > SUM_W'(0))
                s3_q_reg <= s2_sig_reg;
            else
                s3_q_reg <= wide[2*SIG_W-1:SIG_W];
            if (s2_pass_reg)
                s3_kind_reg <= K_PASS;
            else if (s2_sum_reg >= SUM_W'(2047))
                s3_kind_reg <= K_INF;
            else if (s2_sum_reg < -SUM_W'(UNDER_LIM))
                s3_kind_reg <= K_ZERO;
            else if (s2_sum_reg <= SUM_W'(0))
                s3_kind_reg <= K_SUB;
            else
                s3_kind_reg <= K_NORM;
        end
    end

    // Stage 4: rounding and assembly into the output register.
    logic [WORD_W-1:0] result_next;
    logic              up;
    assign up = s3_half_reg && (s3_sticky_reg || s3_q_reg[0]);

    always_comb
    begin
        unique case (s3_kind_reg)
            K_PASS:  result_next = s3_raw_reg;
            K_INF:   result_next = {s3_sign_reg, EXP_MAX, {FRAC_W{1'b0}}};
            K_ZERO:  result_next = {s3_sign_reg, {(WORD_W-1){1'b0}}};
            K_SUB:   result_next = {s3_sign_reg,
                                    (WORD_W-1)'(s3_q_reg) + (WORD_W-1)'(up)};
            K_NORM:  result_next = {s3_sign_reg, s3_exp_reg, s3_q_reg[FRAC_W-1:0]};
            default: result_next = s3_raw_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            result_bits <= result_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            out_valid <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg <= in_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) out_valid <= v3_reg;
        end
    end

`ifndef SYNTHESIS
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(result_bits))
        else $error("result changed while stalled");
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall && v1_reg && v2_reg && v3_reg)
        else $error("input stalled with room in the pipe");
    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        v3_reg && !out_stall |=> out_valid)
        else $error("item lost at the output stage");
`endif
endmodule
`default_nettype wire

### sim/tb_double_power_of_two_scaler.sv
// Testbench for the binary64 power-of-two scaler (ldexp).
// Drives value/scale transfers, checks each result against a typed-in or predicted answer.
// Depends on dpts_pkg and the double_power_of_two_scaler RTL.
`timescale 1ns / 1ps
module tb_double_power_of_two_scaler
    import dpts_pkg::*;
;

    // Special bit patterns used by the directed rows.
    localparam logic [63:0] POS_INF  = 64'h7FF0_0000_0000_0000;
    localparam logic [63:0] NEG_INF  = 64'hFFF0_0000_0000_0000;
    localparam logic [63:0] NEG_ZERO = 64'h8000_0000_0000_0000;
    localparam logic [63:0] ONE      = 64'h3FF0_0000_0000_0000;
    localparam logic [63:0] MIN_NORM = 64'h0010_0000_0000_0000;
    localparam logic [63:0] MIN_SUB  = 64'h0000_0000_0000_0001;
    localparam logic [63:0] MAX_FIN  = 64'h7FEF_FFFF_FFFF_FFFF;
    localparam logic [63:0] QNAN     = 64'h7FF8_0000_0000_0001;
    localparam logic [63:0] SNAN     = 64'hFFF0_0000_0000_0001;
    localparam int          N_DIRECTED = 24;
    localparam int          N_RANDOM   = 1900;

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_stall;
    logic [WORD_W-1:0]         value_bits;
    logic signed [SCALE_W-1:0] scale;
    logic                      out_valid;
    logic                      out_stall;
    logic [WORD_W-1:0]         result_bits;

    // Expected results, oldest first.
    logic [WORD_W-1:0] pending_results[$];
    int                mismatches;
    int                send_idle_pct;
    int                recv_idle_pct;

    // One directed row: a value, a scale, and an optional typed-in answer.
    typedef struct {
        logic [63:0] value;
        logic [31:0] sc;
        bit          known;
        logic [63:0] answer;
    } stim_row_t;

    stim_row_t directed[N_DIRECTED];

    double_power_of_two_scaler i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .value_bits  (value_bits),
        .scale       (scale),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .result_bits (result_bits)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Multiplies a binary64 pattern by two to the power sc, rounding to nearest even.
    function automatic logic [63:0] ldexp_bits(input logic [63:0] v,
                                               input logic signed [31:0] sc);
        logic        sgn;
        logic [10:0] ex;
        logic [52:0] sig;
        longint      biased;
        longint      sum;
        int          shamt;
        logic [63:0] quot;
        logic [63:0] rem;
        logic [63:0] half;
        sgn    = v[63];
        ex     = v[62:52];
        sig    = {1'b1, v[51:0]};
        biased = ex;
        if (ex == EXP_MAX || v[62:0] == '0)
            return v;
        if (ex == '0)
        begin
            // Subnormal input: slide the leading one up to the hidden bit.
            sig    = {1'b0, v[51:0]};
            biased = 1;
            while (!sig[52])
            begin
                sig    = sig << 1;
                biased = biased - 1;
            end
        end
        sum = biased + longint'(sc);
        if (sum >= 2047)
            return {sgn, EXP_MAX, 52'd0};
        if (sum < -UNDER_LIM)
            return {sgn, 63'd0};
        if (sum <= 0)
        begin
            shamt = int'(1 - sum);
            quot  = 64'(sig) >> shamt;
            rem   = 64'(sig) & ((64'd1 << shamt) - 64'd1);
            half  = 64'd1 << (shamt - 1);
            if (rem > half || (rem == half && quot[0]))
                quot = quot + 64'd1;
            return {sgn, 63'd0} | quot;
        end
        return {sgn, sum[10:0], sig[51:0]};
    endfunction

    function automatic logic [63:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    // Random values lean toward the interesting regions: subnormals, exponents near
    // the edges, and scales that land results near overflow or in the subnormal band.
    function automatic logic [63:0] pick_value();
        logic [63:0] v;
        v = rand_word();
        case ($urandom_range(0, 9))
            0: v[62:52] = '0;
            1: v[62:52] = EXP_MAX;
            2: v[62:0]  = '0;
            3: v[62:52] = 11'($urandom_range(1, 60));
            4: v[62:52] = 11'($urandom_range(1990, 2046));
            default: ;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] pick_scale(input logic [63:0] v);
        int e;
        e = v[62:52];
        case ($urandom_range(0, 7))
            0: return $urandom;
            1: return 32'($urandom_range(0, 120)) - 32'(e) - 32'd60;
            2: return 32'd2046 - 32'(e) + 32'($urandom_range(0, 4)) - 32'd2;
            3: return 32'($urandom_range(0, 8)) - 32'(e) - 32'd52;
            4: return 32'($urandom_range(0, 4200)) - 32'd2100;
            5: return {$urandom_range(0, 1) ? 2'b10 : 2'b01, 30'($urandom)};
            default: return 32'($urandom_range(0, 200)) - 32'd100;
        endcase
    endfunction

    // Presents one transfer and holds it until the block takes it.
    task automatic send_item(input logic [63:0] v, input logic [31:0] sc,
                             input bit known, input logic [63:0] answer);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        value_bits <= v;
        scale      <= sc;
        pending_results.push_back(known ? answer : ldexp_bits(v, sc));
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Receiver stall, chosen fresh every cycle.
    always @(posedge clk)
    begin
        if (rst_n)
            out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    // Result checker: compares every accepted result with the oldest expectation.
    always @(posedge clk)
    begin
        logic [63:0] want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches = mismatches + 1;
                if (mismatches <= 10)
                    $display("unexpected result %h", result_bits);
            end
            else
            begin
                want = pending_results.pop_front();
                if (result_bits !== want)
                begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display("result_bits mismatch: expected %h, got %h",
                                 want, result_bits);
                end
            end
        end
    end

    // Watchdog: far beyond the slowest correct run.
    initial
    begin
        #20ms;
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        int k;
        int wait_cycles;
        logic [63:0] v;
        // Directed rows. Passthrough, underflow, exact exponent edits and most overflow rows are
        // typed in; rounding rows and one overflow from a subnormal go through the predictor.
        directed[0]  = '{ONE, 32'd0, 1'b1, ONE};
        directed[1]  = '{64'd0, 32'h7FFF_FFFF, 1'b1, 64'd0};
        directed[2]  = '{NEG_ZERO, 32'h8000_0000, 1'b1, NEG_ZERO};
        directed[3]  = '{POS_INF, 32'h8000_0000, 1'b1, POS_INF};
        directed[4]  = '{NEG_INF, 32'd5, 1'b1, NEG_INF};
        directed[5]  = '{QNAN, 32'd7, 1'b1, QNAN};
        directed[6]  = '{SNAN, 32'hFFFF_FFF0, 1'b1, SNAN};
        directed[7]  = '{ONE, 32'h7FFF_FFFF, 1'b1, POS_INF};
        directed[8]  = '{{1'b1, ONE[62:0]}, 32'h7FFF_FFFF, 1'b1, NEG_INF};
        directed[9]  = '{ONE, 32'h8000_0000, 1'b1, 64'd0};
        directed[10] = '{{1'b1, ONE[62:0]}, 32'h8000_0000, 1'b1, NEG_ZERO};
        directed[11] = '{MAX_FIN, 32'd1, 1'b1, POS_INF};
        directed[12] = '{MAX_FIN, 32'hFFFF_FFFF, 1'b1, 64'h7FDF_FFFF_FFFF_FFFF};
        directed[13] = '{MIN_SUB, 32'd52, 1'b1, MIN_NORM};
        directed[14] = '{MIN_SUB, 32'hFFFF_FFFF, 1'b0, 64'd0};
        directed[15] = '{64'h0000_0000_0000_0003, 32'hFFFF_FFFF, 1'b0, 64'd0};
        directed[16] = '{MIN_NORM, 32'hFFFF_FFFF, 1'b1, 64'h0008_0000_0000_0000};
        directed[17] = '{64'h001F_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 64'd0};
        directed[18] = '{MIN_NORM, 32'hFFFF_FFCA, 1'b0, 64'd0};
        directed[19] = '{MIN_NORM, 32'hFFFF_FFC9, 1'b1, 64'd0};
        directed[20] = '{64'h0018_0000_0000_0000, 32'hFFFF_FFCB, 1'b0, 64'd0};
        directed[21] = '{64'h800F_FFFF_FFFF_FFFF, 32'd2098, 1'b0, 64'd0};
        directed[22] = '{64'hFFFF_FFFF_FFFF_FFFF, 32'd3, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF};
        directed[23] = '{64'h4000_0000_0000_0000, 32'd1023, 1'b1, POS_INF};

        mismatches    = 0;
        send_idle_pct = 22;
        recv_idle_pct = 68;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        out_stall     = 1'b0;
        value_bits    = '0;
        scale         = '0;
        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (k = 0; k < N_DIRECTED; k++)
            send_item(directed[k].value, directed[k].sc, directed[k].known, directed[k].answer);

        // Random part in three idling phases: slow receiver, slow sender, then full rate.
        for (k = 0; k < N_RANDOM; k++)
        begin
            if (k == N_RANDOM / 3)
            begin
                send_idle_pct = 68;
                recv_idle_pct = 22;
            end
            else if (k == 2 * N_RANDOM / 3)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            v = pick_value();
            send_item(v, pick_scale(v), 1'b0, 64'd0);
        end
        in_valid <= 1'b0;

        wait_cycles = 0;
        while (pending_results.size() != 0 && wait_cycles < 100000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (10)
            @(posedge clk);

        if (mismatches == 0 && pending_results.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
